// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SSFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define SSFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ssfc_pkg.sv -----
package ssfc_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int TOL_W     = 16;
    localparam int FRAC_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_TOL    = 3'd4;

    // Register values after reset.
    localparam logic signed [COORD_W-1:0] RST_LEFT_EDGE   = -32'sd65536;
    localparam logic signed [COORD_W-1:0] RST_RIGHT_EDGE  = 32'sd65536;
    localparam logic signed [COORD_W-1:0] RST_BOTTOM_EDGE = -32'sd65536;
    localparam logic signed [COORD_W-1:0] RST_TOP_EDGE    = 32'sd65536;
    localparam logic [TOL_W-1:0]          RST_ZERO_TOL    = 16'd1;

    // Faces, in the order that decides nothing but naming.
    localparam int NUM_FACES   = 4;
    localparam int FACE_BOTTOM = 0;
    localparam int FACE_LEFT   = 1;
    localparam int FACE_TOP    = 2;
    localparam int FACE_RIGHT  = 3;

    // Pipeline depth: eight front stages, a load stage and one stage per quotient bit.
    localparam int FRONT_STAGES = 8;
    localparam int DIV_STEPS    = FRAC_W;
    localparam int NUM_STAGES   = FRONT_STAGES + 1 + DIV_STEPS;

    typedef struct packed {
        logic              ok;
        logic [COORD_W-1:0] n;
    } t_face_pre;

    // Normalizes one face so that the denominator is positive and checks 0 < n < d.
    function automatic t_face_pre face_norm(logic signed [DIFF_W-1:0] num,
                                            logic signed [DIFF_W-1:0] den);
        logic signed [DIFF_W:0] nn;
        logic signed [DIFF_W:0] dd;
        t_face_pre              r;
        nn = den[DIFF_W-1] ? -$signed({num[DIFF_W-1], num})
                           : $signed({num[DIFF_W-1], num});
        dd = den[DIFF_W-1] ? -$signed({den[DIFF_W-1], den})
                           : $signed({den[DIFF_W-1], den});
        r.ok = (den != '0) && !nn[DIFF_W] && (nn != '0) && (nn < dd);
        r.n  = nn[COORD_W-1:0];
        return r;
    endfunction

    // Magnitude of a difference; the range never reaches the most negative code.
    function automatic logic [COORD_W-1:0] mag33(logic signed [DIFF_W-1:0] v);
        logic signed [DIFF_W-1:0] t;
        t = v[DIFF_W-1] ? -v : v;
        return t[COORD_W-1:0];
    endfunction

    // Sign and magnitude to two's complement.
    function automatic logic signed [2*COORD_W:0] sm_signed(logic neg,
                                                           logic [2*COORD_W-1:0] m);
        logic signed [2*COORD_W:0] t;
        t = $signed({1'b0, m});
        return neg ? -t : t;
    endfunction

endpackage

// ----- hdl/ssfc_channels.sv -----
// Segment input channel.
interface ssfc_seg_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssfc_pkg::COORD_W-1:0] start_x;
    logic signed [ssfc_pkg::COORD_W-1:0] start_y;
    logic signed [ssfc_pkg::COORD_W-1:0] start_z;
    logic signed [ssfc_pkg::COORD_W-1:0] end_x;
    logic signed [ssfc_pkg::COORD_W-1:0] end_y;
    logic signed [ssfc_pkg::COORD_W-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

// Result channel.
interface ssfc_res_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [ssfc_pkg::FRAC_W-1:0]  fraction;

    modport source (output valid, hit, fraction, input ready);
    modport sink (input valid, hit, fraction, output ready);
endinterface

// Configuration write channel.
interface ssfc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ssfc_pkg::CFG_IDX_W-1:0]  index;
    logic [ssfc_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/segment_square_first_crossing_core.sv -----
// Segment versus square prism first crossing.
// Channels: i_seg carries one segment (start and end points, signed Q16.16) per
// transaction; o_res returns one transaction per segment with a hit flag and the
// smallest crossing fraction as unsigned Q0.32 (zero when there is no hit).
// i_cfg writes the edge and tolerance registers; it is always ready and should
// only be used while no segment is in flight.
// Each accepted segment passes 41 register stages: eight arithmetic stages, one
// load stage and 32 stages of a restoring divider that produce one quotient bit each.
// Throughput: one segment per cycle unless o_res stalls; results leave in input order.
// Reset clears all stage valid bits and loads the edges with -1.0/+1.0 and the
// tolerance with 2^-16.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// i_seg.ready drops; bubbles are not squeezed out when the output frees up.
module segment_square_first_crossing_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssfc_seg_if.sink          i_seg,
    ssfc_cfg_if.sink          i_cfg,
    ssfc_res_if.source        o_res
);

    localparam int NF = ssfc_pkg::NUM_FACES;
    localparam int FB = ssfc_pkg::FACE_BOTTOM;
    localparam int FL = ssfc_pkg::FACE_LEFT;
    localparam int FT = ssfc_pkg::FACE_TOP;
    localparam int FR = ssfc_pkg::FACE_RIGHT;
    localparam int NS = ssfc_pkg::NUM_STAGES;
    localparam int DS = ssfc_pkg::DIV_STEPS;

    // Configuration registers.
    logic signed [31:0] r_left_edge;
    logic signed [31:0] r_right_edge;
    logic signed [31:0] r_bottom_edge;
    logic signed [31:0] r_top_edge;
    logic [15:0]        r_zero_tol;

    logic        w_adv;
    logic [NS-1:0] r_vld;

    assign i_cfg.ready = 1'b1;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_edge   <= ssfc_pkg::RST_LEFT_EDGE;
            r_right_edge  <= ssfc_pkg::RST_RIGHT_EDGE;
            r_bottom_edge <= ssfc_pkg::RST_BOTTOM_EDGE;
            r_top_edge    <= ssfc_pkg::RST_TOP_EDGE;
            r_zero_tol    <= ssfc_pkg::RST_ZERO_TOL;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ssfc_pkg::REG_LEFT_EDGE:   r_left_edge   <= $signed(i_cfg.data);
                ssfc_pkg::REG_RIGHT_EDGE:  r_right_edge  <= $signed(i_cfg.data);
                ssfc_pkg::REG_BOTTOM_EDGE: r_bottom_edge <= $signed(i_cfg.data);
                ssfc_pkg::REG_TOP_EDGE:    r_top_edge    <= $signed(i_cfg.data);
                ssfc_pkg::REG_ZERO_TOL:    r_zero_tol    <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register is free or drains.
    assign w_adv       = !r_vld[NS-1] || o_res.ready;
    assign i_seg.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_seg.valid};
        end
    end

    // Stage 1: travel and edge offsets.
    logic signed [32:0] r1_dx, r1_dy, r1_dz, r1_xl, r1_xh, r1_yl, r1_yh;
    logic [15:0]        r1_tol;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_dx  <= $signed({i_seg.end_x[31], i_seg.end_x})
                    - $signed({i_seg.start_x[31], i_seg.start_x});
            r1_dy  <= $signed({i_seg.end_y[31], i_seg.end_y})
                    - $signed({i_seg.start_y[31], i_seg.start_y});
            r1_dz  <= $signed({i_seg.end_z[31], i_seg.end_z})
                    - $signed({i_seg.start_z[31], i_seg.start_z});
            r1_xl  <= $signed({r_left_edge[31], r_left_edge})
                    - $signed({i_seg.start_x[31], i_seg.start_x});
            r1_xh  <= $signed({r_right_edge[31], r_right_edge})
                    - $signed({i_seg.start_x[31], i_seg.start_x});
            r1_yl  <= $signed({r_bottom_edge[31], r_bottom_edge})
                    - $signed({i_seg.start_y[31], i_seg.start_y});
            r1_yh  <= $signed({r_top_edge[31], r_top_edge})
                    - $signed({i_seg.start_y[31], i_seg.start_y});
            r1_tol <= r_zero_tol;
        end
    end

    // Stage 2: face normalization and magnitudes.
    ssfc_pkg::t_face_pre w_pre [NF];
    assign w_pre[FB] = ssfc_pkg::face_norm(r1_yl, r1_dy);
    assign w_pre[FL] = ssfc_pkg::face_norm(r1_xl, r1_dx);
    assign w_pre[FT] = ssfc_pkg::face_norm(r1_yh, r1_dy);
    assign w_pre[FR] = ssfc_pkg::face_norm(r1_xh, r1_dx);

    logic [NF-1:0] r2_ok;
    logic [31:0]   r2_n [NF];
    logic [31:0]   r2_mx, r2_my, r2_mz, r2_axl, r2_axh, r2_ayl, r2_ayh;
    logic          r2_sdx, r2_sdy, r2_sxl, r2_sxh, r2_syl, r2_syh;
    logic [15:0]   r2_tol;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int f = 0; f < NF; f++) begin
                r2_ok[f] <= w_pre[f].ok;
                r2_n[f]  <= w_pre[f].n;
            end
            r2_mx  <= ssfc_pkg::mag33(r1_dx);
            r2_my  <= ssfc_pkg::mag33(r1_dy);
            r2_mz  <= ssfc_pkg::mag33(r1_dz);
            r2_axl <= ssfc_pkg::mag33(r1_xl);
            r2_axh <= ssfc_pkg::mag33(r1_xh);
            r2_ayl <= ssfc_pkg::mag33(r1_yl);
            r2_ayh <= ssfc_pkg::mag33(r1_yh);
            r2_sdx <= r1_dx[32];
            r2_sdy <= r1_dy[32];
            r2_sxl <= r1_xl[32];
            r2_sxh <= r1_xh[32];
            r2_syl <= r1_yl[32];
            r2_syh <= r1_yh[32];
            r2_tol <= r1_tol;
        end
    end

    // Stage 3: products for squares, edge tests and tolerance terms.
    logic [63:0]   r3_sqx, r3_sqy, r3_sqz;
    logic [63:0]   r3_pxl, r3_pxh, r3_pyl, r3_pyh;
    logic [63:0]   r3_pm [NF];
    logic [31:0]   r3_n2 [NF];
    logic [31:0]   r3_n [NF];
    logic [NF-1:0] r3_ok;
    logic [31:0]   r3_tol2;
    logic [15:0]   r3_tol;
    logic [31:0]   r3_mx, r3_my;
    logic          r3_sdx, r3_sdy, r3_sxl, r3_sxh, r3_syl, r3_syh;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_sqx <= r2_mx * r2_mx;
            r3_sqy <= r2_my * r2_my;
            r3_sqz <= r2_mz * r2_mz;
            r3_pxl <= r2_axl * r2_my;
            r3_pxh <= r2_axh * r2_my;
            r3_pyl <= r2_ayl * r2_mx;
            r3_pyh <= r2_ayh * r2_mx;
            r3_pm[FB] <= r2_n[FB] * r2_mx;
            r3_pm[FT] <= r2_n[FT] * r2_mx;
            r3_pm[FL] <= r2_n[FL] * r2_my;
            r3_pm[FR] <= r2_n[FR] * r2_my;
            for (int f = 0; f < NF; f++) begin
                r3_n2[f] <= r2_n[f][15:0] * r2_n[f][15:0];
                r3_n[f]  <= r2_n[f];
            end
            r3_ok   <= r2_ok;
            r3_tol2 <= r2_tol * r2_tol;
            r3_tol  <= r2_tol;
            r3_mx   <= r2_mx;
            r3_my   <= r2_my;
            r3_sdx  <= r2_sdx;
            r3_sdy  <= r2_sdy;
            r3_sxl  <= r2_sxl;
            r3_sxh  <= r2_sxh;
            r3_syl  <= r2_syl;
            r3_syh  <= r2_syh;
        end
    end

    // Stage 4: squared length and the strict between-edges tests.
    logic signed [64:0] w_xl_s, w_xh_s, w_yl_s, w_yh_s;
    logic signed [64:0] w_pm_s [NF];
    logic [NF-1:0]      w_btw;

    always_comb begin
        w_xl_s = ssfc_pkg::sm_signed(r3_sxl, r3_pxl);
        w_xh_s = ssfc_pkg::sm_signed(r3_sxh, r3_pxh);
        w_yl_s = ssfc_pkg::sm_signed(r3_syl, r3_pyl);
        w_yh_s = ssfc_pkg::sm_signed(r3_syh, r3_pyh);
        w_pm_s[FB] = ssfc_pkg::sm_signed(r3_sdx, r3_pm[FB]);
        w_pm_s[FT] = ssfc_pkg::sm_signed(r3_sdx, r3_pm[FT]);
        w_pm_s[FL] = ssfc_pkg::sm_signed(r3_sdy, r3_pm[FL]);
        w_pm_s[FR] = ssfc_pkg::sm_signed(r3_sdy, r3_pm[FR]);
        w_btw[FB] = (w_xl_s < w_pm_s[FB]) && (w_pm_s[FB] < w_xh_s);
        w_btw[FT] = (w_xl_s < w_pm_s[FT]) && (w_pm_s[FT] < w_xh_s);
        w_btw[FL] = (w_yl_s < w_pm_s[FL]) && (w_pm_s[FL] < w_yh_s);
        w_btw[FR] = (w_yl_s < w_pm_s[FR]) && (w_pm_s[FR] < w_yh_s);
    end

    logic [65:0]   r4_sq;
    logic [63:0]   r4_sqx, r4_sqy;
    logic [31:0]   r4_n2 [NF];
    logic [31:0]   r4_n [NF];
    logic [NF-1:0] r4_ok;
    logic [31:0]   r4_tol2;
    logic [15:0]   r4_tol;
    logic [31:0]   r4_mx, r4_my;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_sq   <= {2'b0, r3_sqx} + {2'b0, r3_sqy} + {2'b0, r3_sqz};
            r4_sqx  <= r3_sqx;
            r4_sqy  <= r3_sqy;
            r4_n2   <= r3_n2;
            r4_n    <= r3_n;
            r4_ok   <= r3_ok & w_btw;
            r4_tol2 <= r3_tol2;
            r4_tol  <= r3_tol;
            r4_mx   <= r3_mx;
            r4_my   <= r3_my;
        end
    end

    // Stage 5: partial products of both sides of the tolerance test.
    logic [64:0]   r5_pl [NF];
    logic [64:0]   r5_ph [NF];
    logic [63:0]   r5_rxl, r5_rxh, r5_ryl, r5_ryh;
    logic [31:0]   r5_n [NF];
    logic [NF-1:0] r5_ok;
    logic [15:0]   r5_tol;
    logic [31:0]   r5_mx, r5_my;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int f = 0; f < NF; f++) begin
                r5_pl[f] <= r4_sq[32:0] * r4_n2[f];
                r5_ph[f] <= r4_sq[65:33] * r4_n2[f];
            end
            r5_rxl <= r4_tol2 * r4_sqx[31:0];
            r5_rxh <= r4_tol2 * r4_sqx[63:32];
            r5_ryl <= r4_tol2 * r4_sqy[31:0];
            r5_ryh <= r4_tol2 * r4_sqy[63:32];
            r5_n   <= r4_n;
            r5_ok  <= r4_ok;
            r5_tol <= r4_tol;
            r5_mx  <= r4_mx;
            r5_my  <= r4_my;
        end
    end

    // Stage 6: tolerance compare, only binding when the numerator is below it.
    logic [97:0]   w_lhs [NF];
    logic [97:0]   w_rhs_x, w_rhs_y;
    logic [NF-1:0] w_acc;

    always_comb begin
        w_rhs_x = {34'b0, r5_rxl} + {2'b0, r5_rxh, 32'b0};
        w_rhs_y = {34'b0, r5_ryl} + {2'b0, r5_ryh, 32'b0};
        for (int f = 0; f < NF; f++) begin
            w_lhs[f] = {33'b0, r5_pl[f]} + {r5_ph[f], 33'b0};
        end
        w_acc[FB] = r5_ok[FB] && ((r5_n[FB] >= {16'b0, r5_tol}) || (w_lhs[FB] >= w_rhs_y));
        w_acc[FT] = r5_ok[FT] && ((r5_n[FT] >= {16'b0, r5_tol}) || (w_lhs[FT] >= w_rhs_y));
        w_acc[FL] = r5_ok[FL] && ((r5_n[FL] >= {16'b0, r5_tol}) || (w_lhs[FL] >= w_rhs_x));
        w_acc[FR] = r5_ok[FR] && ((r5_n[FR] >= {16'b0, r5_tol}) || (w_lhs[FR] >= w_rhs_x));
    end

    logic [NF-1:0] r6_acc;
    logic [31:0]   r6_n [NF];
    logic [31:0]   r6_mx, r6_my;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_acc <= w_acc;
            r6_n   <= r5_n;
            r6_mx  <= r5_mx;
            r6_my  <= r5_my;
        end
    end

    // Stage 7: within one axis both faces share the denominator, so the smaller
    // numerator wins.
    logic        r7_axh, r7_ayh;
    logic [31:0] r7_axn, r7_ayn, r7_mx, r7_my;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_axh <= r6_acc[FL] || r6_acc[FR];
            r7_ayh <= r6_acc[FB] || r6_acc[FT];
            r7_axn <= (r6_acc[FL] && (!r6_acc[FR] || r6_n[FL] < r6_n[FR]))
                      ? r6_n[FL] : r6_n[FR];
            r7_ayn <= (r6_acc[FB] && (!r6_acc[FT] || r6_n[FB] < r6_n[FT]))
                      ? r6_n[FB] : r6_n[FT];
            r7_mx  <= r6_mx;
            r7_my  <= r6_my;
        end
    end

    // Stage 8: cross products to compare the two axis winners.
    logic        r8_axh, r8_ayh;
    logic [31:0] r8_axn, r8_ayn, r8_mx, r8_my;
    logic [63:0] r8_cx, r8_cy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_cx  <= r7_axn * r7_my;
            r8_cy  <= r7_ayn * r7_mx;
            r8_axh <= r7_axh;
            r8_ayh <= r7_ayh;
            r8_axn <= r7_axn;
            r8_ayn <= r7_ayn;
            r8_mx  <= r7_mx;
            r8_my  <= r7_my;
        end
    end

    // Divider load stage, then one quotient bit per stage.
    logic [31:0] r_dv_rem [DS+1];
    logic [31:0] r_dv_d   [DS+1];
    logic [31:0] r_dv_q   [DS+1];
    logic        r_dv_hit [DS+1];
    logic        w_xwin;

    assign w_xwin = r8_axh && (!r8_ayh || (r8_cx < r8_cy));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv_rem[0] <= w_xwin ? r8_axn : r8_ayn;
            r_dv_d[0]   <= w_xwin ? r8_mx : r8_my;
            r_dv_q[0]   <= '0;
            r_dv_hit[0] <= r8_axh || r8_ayh;
        end
    end

    for (genvar k = 1; k <= DS; k++) begin : g_div
        logic [32:0] w_rem2;
        logic [32:0] w_diff;
        logic        w_ge;

        assign w_rem2 = {r_dv_rem[k-1], 1'b0};
        assign w_diff = w_rem2 - {1'b0, r_dv_d[k-1]};
        assign w_ge   = w_rem2 >= {1'b0, r_dv_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_rem[k] <= w_ge ? w_diff[31:0] : w_rem2[31:0];
                r_dv_d[k]   <= r_dv_d[k-1];
                r_dv_q[k]   <= {r_dv_q[k-1][30:0], w_ge};
                r_dv_hit[k] <= r_dv_hit[k-1];
            end
        end
    end

    // Output register is the last divider stage.
    assign o_res.valid    = r_vld[NS-1];
    assign o_res.hit      = r_dv_hit[DS];
    assign o_res.fraction = r_dv_hit[DS] ? r_dv_q[DS] : '0;

endmodule

// ----- hdl/ssfc_checker.sv -----
`include "assert_macros.svh"

module ssfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_hit,
    input logic [31:0] i_fraction
);

    // Reset empties the pipeline.
    `SSFC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A held result keeps its content.
    `SSFC_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_hit) && $stable(i_fraction)), "stalled result changed")

    // A miss reports a zero fraction.
    `SSFC_ASSERT(a_miss_zero, i_clk, i_rst_n, (i_out_valid && !i_hit) |-> (i_fraction == 32'd0), "miss with nonzero fraction")

    // With nothing waiting at the output, input is taken.
    `SSFC_ASSERT(a_ready_free, i_clk, i_rst_n, (!i_out_valid || i_out_ready) |-> i_in_ready, "input blocked while output free")

endmodule

bind segment_square_first_crossing_core ssfc_checker u_ssfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_fraction  (o_res.fraction)
);

// ----- tb/ssfc_crossing_checker.sv -----
`timescale 1ns / 100ps

// Watches the segment, configuration and result channels, predicts the first
// crossing of each accepted segment and compares it with the returned result.
module ssfc_crossing_checker
    import ssfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ssfc_seg_if  seg,
    ssfc_cfg_if  cfg,
    ssfc_res_if  res,
    output int   o_failures,
    output int   o_pending,
    output int   o_segments,
    output int   o_hits
);

    typedef struct {
        logic              hit;
        logic [FRAC_W-1:0] fraction;
    } t_crossing;

    t_crossing   crossing_q[$];
    longint      left_edge, right_edge, bottom_edge, top_edge;
    logic [TOL_W-1:0] zero_tol;

    // Exact test of one face; on success frac holds the truncated Q0.32 fraction.
    function automatic bit face_crossed(longint num, longint den, longint lo_rel,
                                        longint hi_rel, longint od, logic [99:0] len_sq,
                                        logic [TOL_W-1:0] tol, output logic [31:0] frac);
        logic signed [71:0] pn;
        logic signed [71:0] pl;
        logic signed [71:0] ph;
        logic [199:0]       lhs;
        logic [199:0]       rhs;
        logic [71:0]        quo;
        frac = '0;
        if (den == 0) return 1'b0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0 || num >= den) return 1'b0;
        pn = 72'(od) * 72'(num);
        pl = 72'(lo_rel) * 72'(den);
        ph = 72'(hi_rel) * 72'(den);
        if (!(pl < pn && pn < ph)) return 1'b0;
        // Travel to the crossing is compared with the tolerance as squares.
        if (num < longint'(tol)) begin
            lhs = 200'(len_sq) * 200'(num) * 200'(num);
            rhs = 200'(tol) * 200'(tol) * 200'(den) * 200'(den);
            if (lhs < rhs) return 1'b0;
        end
        quo  = (72'(num) << 32) / 72'(den);
        frac = quo[31:0];
        return 1'b1;
    endfunction

    // Smallest accepted fraction over the four side faces.
    function automatic t_crossing first_crossing(longint xs, longint ys, longint zs,
                                                 longint xe, longint ye, longint ze);
        longint      dx, dy, dz;
        longint      xl, xh, yl, yh;
        logic [99:0] len_sq;
        logic [31:0] f;
        t_crossing   r;
        dx = xe - xs;
        dy = ye - ys;
        dz = ze - zs;
        len_sq = 100'(dx < 0 ? -dx : dx) * 100'(dx < 0 ? -dx : dx)
               + 100'(dy < 0 ? -dy : dy) * 100'(dy < 0 ? -dy : dy)
               + 100'(dz < 0 ? -dz : dz) * 100'(dz < 0 ? -dz : dz);
        xl = left_edge - xs;
        xh = right_edge - xs;
        yl = bottom_edge - ys;
        yh = top_edge - ys;
        r.hit = 1'b0;
        r.fraction = '0;
        if (face_crossed(yl, dy, xl, xh, dx, len_sq, zero_tol, f)) begin
            if (!r.hit || f < r.fraction) r.fraction = f;
            r.hit = 1'b1;
        end
        if (face_crossed(xl, dx, yl, yh, dy, len_sq, zero_tol, f)) begin
            if (!r.hit || f < r.fraction) r.fraction = f;
            r.hit = 1'b1;
        end
        if (face_crossed(yh, dy, xl, xh, dx, len_sq, zero_tol, f)) begin
            if (!r.hit || f < r.fraction) r.fraction = f;
            r.hit = 1'b1;
        end
        if (face_crossed(xh, dx, yl, yh, dy, len_sq, zero_tol, f)) begin
            if (!r.hit || f < r.fraction) r.fraction = f;
            r.hit = 1'b1;
        end
        return r;
    endfunction

    assign o_pending = crossing_q.size();

    // Register shadow, prediction and comparison, all on accepted transactions.
    always @(posedge i_clk) begin
        t_crossing want;
        if (!i_rst_n) begin
            left_edge   = longint'(RST_LEFT_EDGE);
            right_edge  = longint'(RST_RIGHT_EDGE);
            bottom_edge = longint'(RST_BOTTOM_EDGE);
            top_edge    = longint'(RST_TOP_EDGE);
            zero_tol    = RST_ZERO_TOL;
            crossing_q.delete();
            o_failures  = 0;
            o_segments  = 0;
            o_hits      = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_LEFT_EDGE:   left_edge   = longint'($signed(cfg.data));
                    REG_RIGHT_EDGE:  right_edge  = longint'($signed(cfg.data));
                    REG_BOTTOM_EDGE: bottom_edge = longint'($signed(cfg.data));
                    REG_TOP_EDGE:    top_edge    = longint'($signed(cfg.data));
                    REG_ZERO_TOL:    zero_tol    = cfg.data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (crossing_q.size() == 0) begin
                    $error("result transaction with no segment outstanding");
                    o_failures++;
                end else begin
                    want = crossing_q.pop_front();
                    if (res.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, res.hit);
                        o_failures++;
                    end
                    if (res.fraction !== want.fraction) begin
                        $error("fraction: expected %h, got %h", want.fraction,
                               res.fraction);
                        o_failures++;
                    end
                end
            end
            if (seg.valid && seg.ready) begin
                want = first_crossing(longint'(seg.start_x), longint'(seg.start_y),
                                      longint'(seg.start_z), longint'(seg.end_x),
                                      longint'(seg.end_y), longint'(seg.end_z));
                crossing_q.insert(crossing_q.size(), want);
                o_segments++;
                if (want.hit) o_hits++;
            end
        end
    end

endmodule

// ----- tb/segment_square_first_crossing_core_test.sv -----
`timescale 1ns / 100ps

module segment_square_first_crossing_core_test;
    import ssfc_pkg::*;

    localparam int ONE       = 65536;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 50;

    logic i_clk;
    logic i_rst_n;
    int   failures, pending, segments, hits;
    int   burst_left;
    int   idle_cycles;
    int   stall_mode;
    int   stall_count;
    int   edges[4];

    ssfc_seg_if seg ();
    ssfc_cfg_if cfg ();
    ssfc_res_if res ();

    segment_square_first_crossing_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg.sink),
        .i_cfg   (cfg.sink),
        .o_res   (res.source)
    );

    ssfc_crossing_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .seg        (seg),
        .cfg        (cfg),
        .res        (res),
        .o_failures (failures),
        .o_pending  (pending),
        .o_segments (segments),
        .o_hits     (hits)
    );

    // Clock.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver stalls follow a mode that is drawn anew each time stall_count wraps.
    always @(posedge i_clk) begin
        if (stall_count == 0) stall_mode <= $urandom_range(0, 3);
        stall_count <= (stall_count + 1) % 64;
        case (stall_mode)
            0: res.ready <= 1'b1;
            1: res.ready <= ($urandom_range(0, 3) != 0);
            2: res.ready <= ($urandom_range(0, 3) == 0);
            default: res.ready <= stall_count[2];
        endcase
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((seg.valid && seg.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One register write transaction; valid stays up for a following write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_LEFT_EDGE:   edges[0] = value;
            REG_RIGHT_EDGE:  edges[1] = value;
            REG_BOTTOM_EDGE: edges[2] = value;
            REG_TOP_EDGE:    edges[3] = value;
            default: ;
        endcase
    endtask

    // Writes all registers plus a write to an unused index.
    task automatic load_square(int l, int r, int b, int t, int tol);
        write_reg(REG_LEFT_EDGE, l);
        write_reg(REG_RIGHT_EDGE, r);
        write_reg(REG_BOTTOM_EDGE, b);
        write_reg(REG_TOP_EDGE, t);
        write_reg(REG_ZERO_TOL, {16'($urandom_range(0, 65535)), tol[15:0]});
        write_reg(3'($urandom_range(5, 7)), $urandom);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one segment, opening a random gap between bursts.
    task automatic send_segment(int xs, int ys, int zs, int xe, int ye, int ze);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            seg.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        seg.valid   <= 1'b1;
        seg.start_x <= xs;
        seg.start_y <= ys;
        seg.start_z <= zs;
        seg.end_x   <= xe;
        seg.end_y   <= ye;
        seg.end_z   <= ze;
        do @(posedge i_clk); while (!seg.ready);
    endtask

    // Lets the pipeline drain so the registers can be rewritten.
    task automatic wait_idle();
        seg.valid <= 1'b0;
        wait (pending == 0);
        repeat (45) @(posedge i_clk);
    endtask

    // Coordinate drawn in one of several ways around the current square.
    function automatic int pick_coord(int lo_e, int hi_e);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 8 * ONE) - 4 * ONE;
            2:       return ($urandom_range(0, 1) ? lo_e : hi_e) + $urandom_range(0, 2) - 1;
            3:       return $urandom_range(0, 512) - 256;
            default: return lo_e + $urandom_range(0, 3 * ONE) - ONE;
        endcase
    endfunction

    task automatic random_segments(int count);
        int xs, ys, xe, ye, zs, ze;
        repeat (count) begin
            xs = pick_coord(edges[0], edges[1]);
            ys = pick_coord(edges[2], edges[3]);
            xe = pick_coord(edges[0], edges[1]);
            ye = pick_coord(edges[2], edges[3]);
            // Short steps exercise the tolerance test.
            if ($urandom_range(0, 4) == 0) begin
                xe = xs + $urandom_range(0, 64) - 32;
                ye = ys + $urandom_range(0, 64) - 32;
            end
            if ($urandom_range(0, 9) == 0) xe = xs;
            if ($urandom_range(0, 9) == 0) ye = ys;
            zs = $urandom;
            ze = ($urandom_range(0, 1)) ? zs : zs + $urandom_range(0, 128) - 64;
            if ($urandom_range(0, 7) == 0) ze = $urandom;
            send_segment(xs, ys, zs, xe, ye, ze);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        seg.valid   = 1'b0;
        seg.start_x = '0;
        seg.start_y = '0;
        seg.start_z = '0;
        seg.end_x   = '0;
        seg.end_y   = '0;
        seg.end_z   = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        res.ready   = 1'b0;
        stall_mode  = 0;
        stall_count = 0;
        idle_cycles = 0;
        burst_left  = 0;
        edges       = '{-ONE, ONE, -ONE, ONE};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases on the square after reset.
        send_segment(-2 * ONE, 0, 0, 2 * ONE, 0, 0);                 // straight through
        send_segment(0, -2 * ONE, 5, 0, 2 * ONE, 5);                 // vertical through
        send_segment(0, 0, 0, 3 * ONE, 0, 0);                        // from inside out
        send_segment(0, 0, 0, 0, 0, 0);                              // zero length
        send_segment(-2 * ONE, ONE, 0, 2 * ONE, ONE, 0);             // along top edge
        send_segment(-2 * ONE, -2 * ONE, 0, 2 * ONE, 2 * ONE, 0);    // through corners
        send_segment(-ONE, 0, 0, ONE, 0, 0);                         // ends on edges
        send_segment(-2 * ONE, 0, 0, -ONE + 1, 0, 0);                // just reaches in
        send_segment(-ONE - 1, 0, 0, -ONE + 1, 0, 0);                // tiny step
        send_segment(ONE + 1, 0, 0, ONE - 1, 0, 7);                  // tiny step inward
        send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h80000000, 32'h80000000, 32'h80000000);
        send_segment(32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff);
        send_segment(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0);
        send_segment(-ONE - 1, -ONE - 1, 0, 32'h7fffffff, 32'h7fffffff, 0);
        send_segment(-2 * ONE, 0, 0, 32'h7fffffff, 0, 32'h7fffffff);
        send_segment(-ONE - 1, 0, 0, 32'h7fffffff, 0, 0);            // fraction near zero
        send_segment(3 * ONE, 3 * ONE, 0, 4 * ONE, 4 * ONE, 0);      // misses entirely
        send_segment(0, 2 * ONE, 0, 0, -2 * ONE, 0);
        send_segment(2 * ONE, 0, -1, -2 * ONE, 0, 1);
        random_segments(130);
        wait_idle();

        // Zero tolerance on the unit square.
        load_square(-ONE, ONE, -ONE, ONE, 0);
        send_segment(-ONE - 1, 0, 0, -ONE + 1, 0, 0);
        random_segments(150);
        wait_idle();

        // Widest square and largest tolerance.
        load_square(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 65535);
        random_segments(150);
        wait_idle();

        // Swapped and equal edges cannot produce a crossing.
        load_square(2 * ONE, -2 * ONE, ONE, ONE, 100);
        random_segments(150);
        wait_idle();

        // A few ticks wide.
        load_square(0, 3, -5, 2, 1);
        random_segments(150);
        wait_idle();

        // Random square.
        load_square(-$urandom_range(0, 4 * ONE), $urandom_range(1, 4 * ONE),
                    -$urandom_range(0, 4 * ONE), $urandom_range(1, 4 * ONE),
                    $urandom_range(0, 300));
        random_segments(150);

        seg.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Checked %0d segments over six square settings, %0d of them crossing.",
                 segments, hits);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", failures);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
